// File: sv/rhrc_pkg.sv
// ----------------------------------------------------------------------------
// rhrc_pkg
// Shared types and constants for the RGB hue / red classifier.
// ----------------------------------------------------------------------------
package rhrc_pkg;

   localparam int FIELD_BITS   = 16;
   localparam int HUE_BITS     = 9;
   localparam int QUO_BITS     = 6;
   localparam int PREP_STAGES  = 3;
   localparam int RSP_LATENCY  = PREP_STAGES + QUO_BITS + 1;
   localparam int CSR_IDX_BITS = 2;
   localparam int HUE_SECTOR   = 60;

   localparam logic [HUE_BITS-1:0] HUE_FULL_TURN  = 9'd360;
   localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = 9'd120;
   localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE  = 9'd240;
   localparam logic [HUE_BITS-1:0] RED_LOW_RESET  = 9'd12;
   localparam logic [HUE_BITS-1:0] RED_HIGH_RESET = 9'd230;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_RED_HUE_LOW  = 2'd0,
      REG_RED_HUE_HIGH = 2'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic       valid;
      sector_type sector;
      logic       neg;
      logic       grey;
   } meta_type;

endpackage

// File: sv/rhrc_prep.sv
// ----------------------------------------------------------------------------
// rhrc_prep
// Front stages: max/min sector pick, spread and difference, scale by 60.
// ----------------------------------------------------------------------------
module rhrc_prep #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic [SAMPLE_BITS-1:0]                    red,
   input  logic [SAMPLE_BITS-1:0]                    green,
   input  logic [SAMPLE_BITS-1:0]                    blue,
   output rhrc_pkg::meta_type                        meta_out,
   output logic [SAMPLE_BITS+rhrc_pkg::QUO_BITS-1:0] num_out,
   output logic [SAMPLE_BITS-1:0]                    den_out
);
   import rhrc_pkg::*;

   localparam int REM_W = SAMPLE_BITS + QUO_BITS;

   sector_type             sector;
   logic [SAMPLE_BITS-1:0] opa, opb, mx, mn;

   meta_type               m0_ff, m0_in;
   logic [SAMPLE_BITS-1:0] a0_ff, b0_ff, mx0_ff, mn0_ff;

   meta_type               m1_ff, m1_in;
   logic [SAMPLE_BITS-1:0] d1_ff, d1_in, sp1_ff, sp1_in;

   meta_type               m2_ff;
   logic [REM_W-1:0]       n2_ff, n2_in;
   logic [SAMPLE_BITS-1:0] sp2_ff;

   always_comb begin
      if ((red >= green) && (red >= blue)) begin
         sector = SECT_RED;
         mx     = red;
         opa    = green;
         opb    = blue;
      end else if (green >= blue) begin
         sector = SECT_GREEN;
         mx     = green;
         opa    = blue;
         opb    = red;
      end else begin
         sector = SECT_BLUE;
         mx     = blue;
         opa    = red;
         opb    = green;
      end
      if ((red <= green) && (red <= blue)) begin
         mn = red;
      end else if (green <= blue) begin
         mn = green;
      end else begin
         mn = blue;
      end
      m0_in.valid  = in_valid;
      m0_in.sector = sector;
      m0_in.neg    = 1'b0;
      m0_in.grey   = 1'b0;
   end

   always_comb begin
      m1_in      = m0_ff;
      m1_in.neg  = a0_ff < b0_ff;
      sp1_in     = mx0_ff - mn0_ff;
      m1_in.grey = mx0_ff == mn0_ff;
      d1_in      = m1_in.neg ? (b0_ff - a0_ff) : (a0_ff - b0_ff);
   end

   assign n2_in = REM_W'(d1_ff) * REM_W'(HUE_SECTOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         m0_ff <= '0;
         m1_ff <= '0;
         m2_ff <= '0;
      end else begin
         m0_ff <= m0_in;
         m1_ff <= m1_in;
         m2_ff <= m1_ff;
      end
      a0_ff  <= opa;
      b0_ff  <= opb;
      mx0_ff <= mx;
      mn0_ff <= mn;
      d1_ff  <= d1_in;
      sp1_ff <= sp1_in;
      n2_ff  <= n2_in;
      sp2_ff <= sp1_ff;
   end

   assign meta_out = m2_ff;
   assign num_out  = n2_ff;
   assign den_out  = sp2_ff;

endmodule

// File: sv/rhrc_div_cell.sv
// ----------------------------------------------------------------------------
// rhrc_div_cell
// One restoring-division cell: resolves one quotient bit and passes on.
// ----------------------------------------------------------------------------
module rhrc_div_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int SHIFT       = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  rhrc_pkg::meta_type                        meta_in,
   input  logic [SAMPLE_BITS+rhrc_pkg::QUO_BITS-1:0] rem_in,
   input  logic [SAMPLE_BITS-1:0]                    den_in,
   input  logic [rhrc_pkg::QUO_BITS-1:0]             quo_in,
   output rhrc_pkg::meta_type                        meta_out,
   output logic [SAMPLE_BITS+rhrc_pkg::QUO_BITS-1:0] rem_out,
   output logic [SAMPLE_BITS-1:0]                    den_out,
   output logic [rhrc_pkg::QUO_BITS-1:0]             quo_out
);
   import rhrc_pkg::*;

   localparam int REM_W = SAMPLE_BITS + QUO_BITS;

   logic [REM_W-1:0]       dsh;
   logic                   fits;
   meta_type               meta_ff;
   logic [REM_W-1:0]       rem_ff, rem_in_nx;
   logic [SAMPLE_BITS-1:0] den_ff;
   logic [QUO_BITS-1:0]    quo_ff, quo_in_nx;

   always_comb begin
      dsh              = REM_W'(den_in) << SHIFT;
      fits             = rem_in >= dsh;
      rem_in_nx        = fits ? (rem_in - dsh) : rem_in;
      quo_in_nx        = quo_in;
      quo_in_nx[SHIFT] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff <= '0;
      end else begin
         meta_ff <= meta_in;
      end
      rem_ff <= rem_in_nx;
      den_ff <= den_in;
      quo_ff <= quo_in_nx;
   end

   assign meta_out = meta_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign quo_out  = quo_ff;

endmodule

// File: sv/rhrc_finish.sv
// ----------------------------------------------------------------------------
// rhrc_finish
// Sector offset, floor/ceil fix-up, red window test and result register.
// ----------------------------------------------------------------------------
module rhrc_finish #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  rhrc_pkg::meta_type                        meta_in,
   input  logic [SAMPLE_BITS+rhrc_pkg::QUO_BITS-1:0] rem_in,
   input  logic [rhrc_pkg::QUO_BITS-1:0]             quo_in,
   input  logic [rhrc_pkg::HUE_BITS-1:0]             red_low,
   input  logic [rhrc_pkg::HUE_BITS-1:0]             red_high,
   output logic                                      rsp_valid,
   output logic [rhrc_pkg::HUE_BITS-1:0]             rsp_hue,
   output logic                                      rsp_red
);
   import rhrc_pkg::*;

   logic [QUO_BITS:0]   qfloor, qceil, mag;
   logic [HUE_BITS-1:0] base, hue_in;
   logic                red_in;
   logic                valid_ff;
   logic [HUE_BITS-1:0] hue_ff;
   logic                red_ff;

   always_comb begin
      qfloor = {1'b0, quo_in};
      qceil  = qfloor + (QUO_BITS+1)'(rem_in != '0);
      mag    = meta_in.neg ? qceil : qfloor;
      unique case (meta_in.sector)
         SECT_RED:   base = meta_in.neg ? HUE_FULL_TURN : '0;
         SECT_GREEN: base = HUE_GREEN_BASE;
         SECT_BLUE:  base = HUE_BLUE_BASE;
         default:    base = '0;
      endcase
      if (meta_in.grey) begin
         hue_in = '0;
      end else if (meta_in.neg) begin
         hue_in = base - HUE_BITS'(mag);
      end else begin
         hue_in = base + HUE_BITS'(mag);
      end
      red_in = (hue_in > red_high) || (hue_in < red_low);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= meta_in.valid;
      end
      hue_ff <= hue_in;
      red_ff <= red_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_hue   = hue_ff;
   assign rsp_red   = red_ff;

endmodule

// File: sv/rgb_hue_red_classifier.sv
// ----------------------------------------------------------------------------
// rgb_hue_red_classifier
// HSV hue of one RGB sample in whole degrees, with a red-window flag.
//
// channel  ports                         transfer
// -------  ----------------------------  ------------------------------------
// request  start, busy, req_*_level      start high, busy low at clock edge
// result   rsp_valid, rsp_hue_degrees,   rsp_valid high for one cycle
//          rsp_is_red
// config   csr_valid, csr_ready,         csr_valid and csr_ready both high
//          csr_index, csr_wdata
//
// One sample per cycle whenever busy is low. The pipeline is 3 prep
// stages, one divider cell per quotient bit (6), and one output stage.
// Busy is high only during reset. Synchronous reset
// drops samples in flight and loads the window bounds to 12 and 230.
// Results cannot be stalled; csr_ready is always high.
// ----------------------------------------------------------------------------
module rgb_hue_red_classifier #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [rhrc_pkg::FIELD_BITS-1:0]        req_red_level,
   input  logic [rhrc_pkg::FIELD_BITS-1:0]        req_green_level,
   input  logic [rhrc_pkg::FIELD_BITS-1:0]        req_blue_level,
   output logic                                   rsp_valid,
   output logic [rhrc_pkg::HUE_BITS-1:0]          rsp_hue_degrees,
   output logic                                   rsp_is_red,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rhrc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rhrc_pkg::HUE_BITS-1:0]          csr_wdata
);
   import rhrc_pkg::*;

   localparam int REM_W = SAMPLE_BITS + QUO_BITS;

   logic                   in_valid;
   logic [HUE_BITS-1:0]    red_low_ff, red_high_ff;

   meta_type               meta_c [QUO_BITS+1];
   logic [REM_W-1:0]       rem_c  [QUO_BITS+1];
   logic [SAMPLE_BITS-1:0] den_c  [QUO_BITS+1];
   logic [QUO_BITS-1:0]    quo_c  [QUO_BITS+1];

   assign busy      = reset;
   assign in_valid  = start && !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_low_ff  <= RED_LOW_RESET;
         red_high_ff <= RED_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_RED_HUE_LOW) begin
            red_low_ff <= csr_wdata;
         end
         if (csr_index == REG_RED_HUE_HIGH) begin
            red_high_ff <= csr_wdata;
         end
      end
   end

   rhrc_prep #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .red      (req_red_level[SAMPLE_BITS-1:0]),
      .green    (req_green_level[SAMPLE_BITS-1:0]),
      .blue     (req_blue_level[SAMPLE_BITS-1:0]),
      .meta_out (meta_c[0]),
      .num_out  (rem_c[0]),
      .den_out  (den_c[0])
   );

   assign quo_c[0] = '0;

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      rhrc_div_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .SHIFT       (QUO_BITS - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .meta_in  (meta_c[i]),
         .rem_in   (rem_c[i]),
         .den_in   (den_c[i]),
         .quo_in   (quo_c[i]),
         .meta_out (meta_c[i+1]),
         .rem_out  (rem_c[i+1]),
         .den_out  (den_c[i+1]),
         .quo_out  (quo_c[i+1])
      );
   end

   rhrc_finish #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .meta_in   (meta_c[QUO_BITS]),
      .rem_in    (rem_c[QUO_BITS]),
      .quo_in    (quo_c[QUO_BITS]),
      .red_low   (red_low_ff),
      .red_high  (red_high_ff),
      .rsp_valid (rsp_valid),
      .rsp_hue   (rsp_hue_degrees),
      .rsp_red   (rsp_is_red)
   );

   logic unused_den;
   assign unused_den = ^den_c[QUO_BITS];

endmodule

// File: sv/rhrc_checker.sv
// ----------------------------------------------------------------------------
// rhrc_checker
// Port-level checks on the RGB hue / red classifier.
// ----------------------------------------------------------------------------
module rhrc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [rhrc_pkg::HUE_BITS-1:0]     rsp_hue_degrees,
   input logic                              csr_valid,
   input logic                              csr_ready
);
   import rhrc_pkg::*;

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue_degrees < HUE_FULL_TURN))
      else $error("hue out of range");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("request transfer without result");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without request transfer");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write held off");

endmodule

bind rgb_hue_red_classifier rhrc_checker u_rhrc_checker (.*);

// File: dv/rgb_hue_red_classifier_test.sv
// ----------------------------------------------------------------------------
// rgb_hue_red_classifier_test
// Self-checking bench for the RGB hue / red-window classifier.
//
// Samples go out from a queue through a clocked driver that adds random idle
// bursts. Each accepted sample is scored by a local hue model, and a clocked
// monitor compares every result strobe with the oldest prediction. The
// window bounds are reprogrammed between drained phases: reset values, fully
// open, fully red, unmapped indexes, random bounds and zero bounds.
// ----------------------------------------------------------------------------
module rgb_hue_red_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rhrc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 50;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_B = 2'd3;
   localparam int                      LEVEL_MAX      = 65535;
   localparam logic [HUE_BITS-1:0]     BOUND_MAX      = '1;

   typedef struct {
      logic [FIELD_BITS-1:0] red;
      logic [FIELD_BITS-1:0] green;
      logic [FIELD_BITS-1:0] blue;
   } rgb_sample_type;

   typedef struct {
      logic [HUE_BITS-1:0] hue;
      logic                is_red;
   } hue_result_type;

   typedef struct {
      logic [CSR_IDX_BITS-1:0] index;
      logic [HUE_BITS-1:0]     data;
   } bound_write_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [FIELD_BITS-1:0]   req_red_level = '0;
   logic [FIELD_BITS-1:0]   req_green_level = '0;
   logic [FIELD_BITS-1:0]   req_blue_level = '0;
   logic                    rsp_valid;
   logic [HUE_BITS-1:0]     rsp_hue_degrees;
   logic                    rsp_is_red;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [HUE_BITS-1:0]     csr_wdata = '0;

   rgb_sample_type  pending_samples[$];
   bound_write_type pending_bounds[$];
   hue_result_type  predicted_hues[$];

   logic [HUE_BITS-1:0] red_low_bound;
   logic [HUE_BITS-1:0] red_high_bound;
   int                  idle_left = 0;
   bit                  no_idle = 1'b0;
   int                  mismatch_count = 0;
   int                  sample_count = 0;
   int                  checked_count = 0;
   int                  window_count = 1;
   int                  cycle_count = 0;

   rgb_hue_red_classifier dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .rsp_valid       (rsp_valid),
      .rsp_hue_degrees (rsp_hue_degrees),
      .rsp_is_red      (rsp_is_red),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1ns clock = ~clock;

   // floor(60 * (a - b) / spread), rounding toward minus infinity
   function automatic int sector_offset(input int a, input int b, input int spread);
      if (a >= b) begin
         return (HUE_SECTOR * (a - b)) / spread;
      end
      return -((HUE_SECTOR * (b - a) + spread - 1) / spread);
   endfunction

   function automatic hue_result_type predict_hue(input rgb_sample_type s);
      hue_result_type res;
      int r, g, b, hi, lo, spread, h;
      r = int'(s.red);
      g = int'(s.green);
      b = int'(s.blue);
      hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      spread = hi - lo;
      if (spread == 0) begin
         h = 0;
      end else if (hi == r) begin
         h = (int'(HUE_FULL_TURN) + sector_offset(g, b, spread)) % int'(HUE_FULL_TURN);
      end else if (hi == g) begin
         h = int'(HUE_GREEN_BASE) + sector_offset(b, r, spread);
      end else begin
         h = int'(HUE_BLUE_BASE) + sector_offset(r, g, spread);
      end
      res.hue = h[HUE_BITS-1:0];
      res.is_red = (res.hue > red_high_bound) || (res.hue < red_low_bound);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $realtime, what);
      end
   endtask

   task automatic push_sample(input int r, input int g, input int b);
      rgb_sample_type s;
      s.red = r[FIELD_BITS-1:0];
      s.green = g[FIELD_BITS-1:0];
      s.blue = b[FIELD_BITS-1:0];
      pending_samples.push_back(s);
   endtask

   // mix of full-range, tiny (ties and grey), near-grey and rail values
   task automatic queue_random(input int count);
      int v[3];
      int base;
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 5);
         base = $urandom_range(0, 65535 - 8);
         for (int c = 0; c < 3; c++) begin
            case (mode)
               3: v[c] = $urandom_range(0, 7);
               4: v[c] = base + $urandom_range(0, 8);
               5: begin
                  case ($urandom_range(0, 2))
                     0: v[c] = 0;
                     1: v[c] = LEVEL_MAX;
                     default: v[c] = $urandom_range(0, 65535);
                  endcase
               end
               default: v[c] = $urandom_range(0, 65535);
            endcase
         end
         push_sample(v[0], v[1], v[2]);
      end
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || predicted_hues.size() != 0 || start) begin
         @(negedge clock);
      end
   endtask

   task automatic write_bound(input logic [CSR_IDX_BITS-1:0] index,
                              input logic [HUE_BITS-1:0] data);
      bound_write_type w;
      w.index = index;
      w.data = data;
      pending_bounds.push_back(w);
      while (pending_bounds.size() != 0 || csr_valid) begin
         @(negedge clock);
      end
   endtask

   // driver: bound writes and sample transfers, with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         red_low_bound = RED_LOW_RESET;
         red_high_bound = RED_HIGH_RESET;
         idle_left = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RED_HUE_LOW:  red_low_bound = csr_wdata;
               REG_RED_HUE_HIGH: red_high_bound = csr_wdata;
               default: ;
            endcase
            void'(pending_bounds.pop_front());
         end
         if (pending_bounds.size() != 0) begin
            csr_valid <= 1'b1;
            csr_index <= pending_bounds[0].index;
            csr_wdata <= pending_bounds[0].data;
         end else begin
            csr_valid <= 1'b0;
         end

         if (start && !busy) begin
            predicted_hues.push_back(predict_hue(pending_samples.pop_front()));
            sample_count++;
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_samples.size() != 0 && !no_idle &&
                         $urandom_range(0, 24) == 0) begin
               idle_left = $urandom_range(1, 13) - 1;
               start <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               start <= 1'b1;
               req_red_level <= pending_samples[0].red;
               req_green_level <= pending_samples[0].green;
               req_blue_level <= pending_samples[0].blue;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every result strobe against the oldest prediction
   always @(posedge clock) begin
      hue_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (predicted_hues.size() == 0) begin
            report_mismatch($sformatf("unexpected result: hue %0d is_red %0b",
                                      rsp_hue_degrees, rsp_is_red));
         end else begin
            want = predicted_hues.pop_front();
            if (rsp_hue_degrees !== want.hue) begin
               report_mismatch($sformatf("hue %0d, predicted %0d",
                                         rsp_hue_degrees, want.hue));
            end
            if (rsp_is_red !== want.is_red) begin
               report_mismatch($sformatf("is_red %0b, predicted %0b for hue %0d",
                                         rsp_is_red, want.is_red, want.hue));
            end
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, predicted_hues.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [HUE_BITS-1:0] low_pick;
      logic [HUE_BITS-1:0] high_pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset window: grey, primaries, tie order, floor on negative offsets
      push_sample(0, 0, 0);
      push_sample(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
      push_sample(100, 100, 100);
      push_sample(LEVEL_MAX, 0, 0);
      push_sample(0, LEVEL_MAX, 0);
      push_sample(0, 0, LEVEL_MAX);
      push_sample(100, 100, 0);
      push_sample(0, 100, 100);
      push_sample(100, 0, 100);
      push_sample(100, 0, 1);
      push_sample(7, 1, 0);
      push_sample(1, 7, 0);
      push_sample(0, 7, 1);
      push_sample(0, 1, 7);
      push_sample(1, 0, 7);
      push_sample(LEVEL_MAX, LEVEL_MAX - 1, 0);
      push_sample(LEVEL_MAX, 0, LEVEL_MAX - 1);
      push_sample(0, LEVEL_MAX, 1);
      push_sample(1, LEVEL_MAX, 0);
      push_sample(LEVEL_MAX, 1, 0);
      push_sample('h5555, 'hAAAA, LEVEL_MAX);
      push_sample('hAAAA, 'h5555, 0);
      queue_random(250);
      wait_drained();

      // open window: nothing red
      write_bound(REG_RED_HUE_LOW, '0);
      write_bound(REG_RED_HUE_HIGH, HUE_BITS'(HUE_FULL_TURN - 1));
      window_count++;
      queue_random(200);
      wait_drained();

      // bounds at the top of the field; unmapped indexes must not stick
      write_bound(REG_RED_HUE_LOW, BOUND_MAX);
      write_bound(REG_RED_HUE_HIGH, BOUND_MAX);
      write_bound(CSR_UNMAPPED_A, HUE_BITS'($urandom_range(0, 511)));
      write_bound(CSR_UNMAPPED_B, HUE_BITS'($urandom_range(0, 511)));
      window_count++;
      queue_random(150);
      wait_drained();

      for (int k = 0; k < 3; k++) begin
         low_pick = HUE_BITS'($urandom_range(0, 359));
         high_pick = HUE_BITS'($urandom_range(0, 359));
         write_bound(REG_RED_HUE_LOW, low_pick);
         write_bound(REG_RED_HUE_HIGH, high_pick);
         window_count++;
         queue_random(150);
         wait_drained();
      end

      // closing phase back to back, red whenever hue is nonzero
      write_bound(REG_RED_HUE_LOW, '0);
      write_bound(REG_RED_HUE_HIGH, '0);
      window_count++;
      no_idle = 1'b1;
      queue_random(200);
      wait_drained();

      repeat (RSP_LATENCY + 4) @(negedge clock);
      $display("Ran %0d samples across %0d window settings, %0d results checked,",
               sample_count, window_count, checked_count);
      $display("covering grey, tie order, sector wrap and out-of-range bounds.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
